// ===== rtl/core/sync_length_crc16_deframer_core_macros.svh =====
// Assertion helpers for the deframer core.
`ifndef SYNC_LENGTH_CRC16_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_CRC16_DEFRAMER_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SLCD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SLCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slcd_pkg.sv =====
package slcd_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'h54;  // 'T'
    localparam logic [7:0]  SYNC_SECOND     = 8'h47;  // 'G'
    localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd1024;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_CRC_LO  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_OK      = 2'd1,
        ST_BAD_CRC = 2'd2,
        ST_BAD_LEN = 2'd3
    } status_t;

    // CRC-16/ARC, one byte, LSB first
    function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/slcd_ifs.sv =====
interface slcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_status, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input frame_status, output ready);
endinterface

interface slcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_payload_len;

    modport source (output valid, output max_payload_len, input ready);
    modport sink   (input valid, input max_payload_len, output ready);
endinterface

// ===== rtl/core/sync_length_crc16_deframer_core.sv =====
// Byte-serial deframer: hunts for the sync pair 'T','G', reads a big-endian
// 16-bit length, passes that many payload bytes straight through, then checks
// a big-endian CRC-16/ARC (reflected 0x8005, init 0, no final xor) taken over
// the payload. Every input transfer yields exactly one result transfer:
// payload_valid/payload_byte flag pass-through payload bytes, and
// frame_status reports ok or CRC mismatch on the last CRC byte, or a rejected
// length (zero or above max_payload_len) on the second length byte. Payload
// is not buffered, so the consumer must drop a frame whose status is a
// mismatch. One byte per cycle sustained while the consumer is ready. Each
// result is valid in the cycle after its input transfer, in the single result
// register (fed by the CRC check and phase decode); that register frees in the
// same cycle it is taken, so a stalled consumer stalls the input only while
// that register is full. max_payload_len resets to 1024 and may be written
// any time the block is idle; the config port is always ready.
module sync_length_crc16_deframer_core (
    input  logic clk,
    input  logic rst_n,
    slcd_in_if.sink    rx,
    slcd_out_if.source res,
    slcd_cfg_if.sink   cfg
);
    import slcd_pkg::*;

    `include "sync_length_crc16_deframer_core_macros.svh"

    // frame state
    phase_t      phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] max_len_reg;

    // result register
    logic        out_valid_reg;
    logic        pay_valid_reg, pay_valid_next;
    logic [7:0]  pay_byte_reg, pay_byte_next;
    status_t     status_reg, status_next;

    logic        accept;
    logic [15:0] len_full;
    logic        len_ok;
    logic [15:0] seen_inc;

    // input can move whenever the result slot is empty or draining this cycle
    assign rx.ready  = !out_valid_reg || res.ready;
    assign accept    = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign len_full = {frame_length_reg[15:8], rx.rx_byte};
    assign len_ok   = (len_full != 16'd0) && (len_full <= max_len_reg);
    assign seen_inc = bytes_seen_reg + 16'd1;

    // next phase and frame bookkeeping
    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        crc_high_next     = crc_high_reg;
        running_crc_next  = running_crc_reg;
        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (rx.rx_byte == SYNC_FIRST)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                // a non-'G' byte is not rechecked as a fresh 'T'
                phase_next = (rx.rx_byte == SYNC_SECOND) ? PH_LEN_HI : PH_HUNT1;
            end
            PH_LEN_HI:
            begin
                frame_length_next = {rx.rx_byte, 8'h00};
                phase_next        = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_length_next = len_full;
                if (len_ok)
                begin
                    bytes_seen_next  = 16'd0;
                    running_crc_next = 16'd0;
                    phase_next       = PH_PAYLOAD;
                end
                else
                    phase_next = PH_HUNT1;
            end
            PH_PAYLOAD:
            begin
                running_crc_next = crc_arc_byte(running_crc_reg, rx.rx_byte);
                bytes_seen_next  = seen_inc;
                if (seen_inc == frame_length_reg)
                    phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                crc_high_next = rx.rx_byte;
                phase_next    = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                phase_next = PH_HUNT1;
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // result fields for this byte
    always_comb
    begin
        pay_valid_next = 1'b0;
        pay_byte_next  = 8'h00;
        status_next    = ST_NONE;
        unique case (phase_reg)
            PH_LEN_LO:
            begin
                if (!len_ok)
                    status_next = ST_BAD_LEN;
            end
            PH_PAYLOAD:
            begin
                pay_valid_next = 1'b1;
                pay_byte_next  = rx.rx_byte;
            end
            PH_CRC_LO:
            begin
                status_next = ({crc_high_reg, rx.rx_byte} == running_crc_reg)
                              ? ST_OK : ST_BAD_CRC;
            end
            default:
            begin
                status_next = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT1;
            frame_length_reg <= 16'd0;
            bytes_seen_reg   <= 16'd0;
            crc_high_reg     <= 8'h00;
            running_crc_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_seen_reg   <= bytes_seen_next;
            crc_high_reg     <= crc_high_next;
            running_crc_reg  <= running_crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg.valid && cfg.ready)
            max_len_reg <= cfg.max_payload_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // payload side of the result register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pay_valid_reg <= pay_valid_next;
            pay_byte_reg  <= pay_byte_next;
            status_reg    <= status_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.payload_valid = pay_valid_reg;
    assign res.payload_byte  = pay_byte_reg;
    assign res.frame_status  = status_reg;

    `SLCD_ASSERT_NEXT(a_payload_passes, accept && (phase_reg == PH_PAYLOAD), out_valid_reg && pay_valid_reg, "payload byte not flagged")
    `SLCD_ASSERT_NEXT(a_bad_len_hunts, accept && (phase_reg == PH_LEN_LO) && !len_ok, (phase_reg == PH_HUNT1) && (status_reg == ST_BAD_LEN), "rejected length not reported")
    `SLCD_ASSERT(a_byte_zero_idle, !(out_valid_reg && !pay_valid_reg) || (pay_byte_reg == 8'h00), "payload byte nonzero without valid")
    `SLCD_ASSERT(a_count_in_range, (phase_reg != PH_PAYLOAD) || (bytes_seen_reg < frame_length_reg), "payload count past frame length")

endmodule
